[rtl/rvx_pkg.sv]
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants of the RV32I execute block: opcodes, the
// instruction classes found by the front end, queue entries and back-end
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef enum logic [3:0] {
        CL_IMAGE,
        CL_OP,
        CL_OPIMM,
        CL_LOAD,
        CL_STORE,
        CL_BRANCH,
        CL_JAL,
        CL_JALR,
        CL_LUI,
        CL_AUIPC,
        CL_SYSTEM,
        CL_ILLEGAL
    } cls_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] word;
        logic [15:0] img_addr;
        logic [7:0]  img_byte;
        cls_t        cls;
        logic        illegal;
    } q_item_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        illegal;
    } result_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC,
        BK_LOAD
    } bk_state_t;

endpackage

`default_nettype wire

[rtl/rvx_ifs.sv]
// ----------------------------------------------------------------------------
// rvx interfaces
// Valid/ready channels carrying the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] instr_word;
    logic [15:0] image_address;
    logic [7:0]  image_byte;

    modport source (output valid, mode, instr_word, image_address, image_byte,
                    input ready);
    modport sink   (input valid, mode, instr_word, image_address, image_byte,
                    output ready);
endinterface

interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        illegal;

    modport source (output valid, next_pc, reg_written, dest_index, dest_value, illegal,
                    input ready);
    modport sink   (input valid, next_pc, reg_written, dest_index, dest_value, illegal,
                    output ready);
endinterface

`default_nettype wire

[rtl/rvx_front.sv]
// ----------------------------------------------------------------------------
// rvx_front
// Accepts items, classifies the instruction word and checks its encoding,
// and holds the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_front import rvx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rvx_in_if.sink     in_ch,
    input  bk_status_t status,
    output q_item_t    q_item,
    output logic       q_valid,
    input  logic       q_pop
);

    q_item_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    q_item_t     dec;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;

    assign in_ch.ready = (count_reg != 2'd2) && !status.clearing;
    assign push        = in_ch.valid && in_ch.ready;

    assign opc = in_ch.instr_word[6:0];
    assign f3  = in_ch.instr_word[14:12];
    assign f7  = in_ch.instr_word[31:25];

    always_comb
    begin
        dec.mode     = in_ch.mode;
        dec.word     = in_ch.instr_word;
        dec.img_addr = in_ch.image_address;
        dec.img_byte = in_ch.image_byte;
        dec.cls      = CL_ILLEGAL;
        if (in_ch.mode)
        begin
            dec.cls = CL_IMAGE;
        end
        else
        begin
            unique case (opc)
                OPC_OP:
                    if (f7 == F7_ZERO || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
                        dec.cls = CL_OP;
                OPC_OPIMM:
                    if ((f3 != 3'd1 && f3 != 3'd5) || f7 == F7_ZERO
                        || (f3 == 3'd5 && f7 == F7_ALT))
                        dec.cls = CL_OPIMM;
                OPC_LOAD:
                    if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7)
                        dec.cls = CL_LOAD;
                OPC_STORE:
                    if (f3 <= 3'd2)
                        dec.cls = CL_STORE;
                OPC_BRANCH:
                    if (f3 != 3'd2 && f3 != 3'd3)
                        dec.cls = CL_BRANCH;
                OPC_JAL:
                    dec.cls = CL_JAL;
                OPC_JALR:
                    if (f3 == 3'd0)
                        dec.cls = CL_JALR;
                OPC_LUI:
                    dec.cls = CL_LUI;
                OPC_AUIPC:
                    dec.cls = CL_AUIPC;
                OPC_SYSTEM:
                    if (in_ch.instr_word == WORD_ECALL || in_ch.instr_word == WORD_EBREAK)
                        dec.cls = CL_SYSTEM;
                default:
                    dec.cls = CL_ILLEGAL;
            endcase
        end
        dec.illegal = (dec.cls == CL_ILLEGAL);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/rvx_back.sv]
// ----------------------------------------------------------------------------
// rvx_back
// Carries out classified items: register file read, execute, data memory
// access in four byte banks, write-back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_back import rvx_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_item_t    q_item,
    input  logic       q_valid,
    output logic       q_pop,
    output bk_status_t status,
    rvx_out_if.source  res_ch
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;

    bk_state_t   state_reg;
    bk_state_t   state_next;
    logic [RW-1:0] clr_reg;
    logic [RW-1:0] clr_next;

    q_item_t     item_reg;
    logic [31:0] rs1_reg;
    logic [31:0] rs2_reg;
    logic [31:0] pc_reg;
    logic [1:0]  alo_reg;

    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] rs1_rd;
    logic [31:0] rs2_rd;

    logic [7:0]  bank_q [4];

    logic        can_out;
    logic        finish;
    logic        mem_rd;
    logic        mem_wr;
    logic [3:0]  byte_en;
    logic [31:0] wr_data;
    logic [31:0] a_base;
    result_t     res;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [31:0] w;
    logic [4:0]  rd_idx;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [31:0] alu;
    logic [31:0] ld_word;
    logic [31:0] ld_val;
    logic        take;
    logic        wr;
    logic [31:0] val;
    logic [31:0] npc;

    assign status.clearing = (state_reg == BK_CLEAR);
    assign can_out = !out_valid_reg || res_ch.ready;

    assign w      = item_reg.word;
    assign rd_idx = w[11:7];
    assign f3     = w[14:12];
    assign imm_i  = {{20{w[31]}}, w[31:20]};
    assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign opb    = (item_reg.cls == CL_OP) ? rs2_reg : imm_i;
    assign shamt  = opb[4:0];

    always_comb
    begin
        unique case (f3)
            3'd0: alu = (item_reg.cls == CL_OP && w[30]) ? rs1_reg - opb : rs1_reg + opb;
            3'd1: alu = rs1_reg << shamt;
            3'd2: alu = {31'd0, $signed(rs1_reg) < $signed(opb)};
            3'd3: alu = {31'd0, rs1_reg < opb};
            3'd4: alu = rs1_reg ^ opb;
            3'd5: alu = w[30] ? 32'($signed(rs1_reg) >>> shamt) : rs1_reg >> shamt;
            3'd6: alu = rs1_reg | opb;
            default: alu = rs1_reg & opb;
        endcase
    end

    always_comb
    begin
        unique case (f3)
            3'd0: take = (rs1_reg == rs2_reg);
            3'd1: take = (rs1_reg != rs2_reg);
            3'd4: take = $signed(rs1_reg) < $signed(rs2_reg);
            3'd5: take = $signed(rs1_reg) >= $signed(rs2_reg);
            3'd6: take = rs1_reg < rs2_reg;
            3'd7: take = rs1_reg >= rs2_reg;
            default: take = 1'b0;
        endcase
    end

    // Byte k of a load sits in the bank selected by the low address bits.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ld_word[8*k +: 8] = bank_q[2'(alo_reg + 2'(k))];
        end
        unique case (f3)
            3'd0: ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
            3'd1: ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
            3'd4: ld_val = {24'd0, ld_word[7:0]};
            3'd5: ld_val = {16'd0, ld_word[15:0]};
            default: ld_val = ld_word;
        endcase
    end

    always_comb
    begin
        wr  = 1'b0;
        val = 32'd0;
        npc = pc_reg + 32'd4;
        unique case (item_reg.cls)
            CL_OP, CL_OPIMM:
            begin
                wr  = 1'b1;
                val = alu;
            end
            CL_LOAD:
            begin
                wr  = 1'b1;
                val = ld_val;
            end
            CL_BRANCH:
                if (take)
                    npc = pc_reg + imm_b;
            CL_JAL:
            begin
                wr  = 1'b1;
                val = pc_reg + 32'd4;
                npc = pc_reg + imm_j;
            end
            CL_JALR:
            begin
                wr  = 1'b1;
                val = pc_reg + 32'd4;
                npc = (rs1_reg + imm_i) & ~32'd1;
            end
            CL_LUI:
            begin
                wr  = 1'b1;
                val = {w[31:12], 12'd0};
            end
            CL_AUIPC:
            begin
                wr  = 1'b1;
                val = pc_reg + {w[31:12], 12'd0};
            end
            CL_IMAGE, CL_ILLEGAL:
                npc = pc_reg;
            default:
                npc = pc_reg + 32'd4;
        endcase
        res.illegal     = item_reg.illegal;
        res.next_pc     = npc;
        res.reg_written = wr && (rd_idx != 5'd0);
        res.dest_index  = res.reg_written ? rd_idx : 5'd0;
        res.dest_value  = res.reg_written ? val : 32'd0;
    end

    // Next state.
    always_comb
    begin
        clr_next   = clr_reg;
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == RW'(ROWS - 1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
                if (q_valid)
                    state_next = BK_EXEC;
            BK_EXEC:
                if (item_reg.cls == CL_LOAD)
                    state_next = BK_LOAD;
                else if (can_out)
                    state_next = q_valid ? BK_EXEC : BK_IDLE;
            BK_LOAD:
                if (can_out)
                    state_next = q_valid ? BK_EXEC : BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        finish = 1'b0;
        mem_rd = 1'b0;
        mem_wr = 1'b0;
        unique case (state_reg)
            BK_EXEC:
                if (item_reg.cls == CL_LOAD)
                    mem_rd = 1'b1;
                else
                begin
                    finish = can_out;
                    mem_wr = can_out
                        && (item_reg.cls == CL_STORE || item_reg.cls == CL_IMAGE);
                end
            BK_LOAD:
                finish = can_out;
            default:
                finish = 1'b0;
        endcase
        q_pop = q_valid && (state_reg == BK_IDLE || finish);
    end

    always_comb
    begin
        if (item_reg.cls == CL_IMAGE)
        begin
            a_base  = {16'd0, item_reg.img_addr};
            wr_data = {24'd0, item_reg.img_byte};
            byte_en = 4'b0001;
        end
        else
        begin
            a_base  = rs1_reg + ((item_reg.cls == CL_STORE) ? imm_s : imm_i);
            wr_data = rs2_reg;
            unique case (f3)
                3'd0: byte_en = 4'b0001;
                3'd1: byte_en = 4'b0011;
                default: byte_en = 4'b1111;
            endcase
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0]    mem [ROWS];
        logic [1:0]    k;
        logic [31:0]   ab;
        logic [RW-1:0] row;

        assign k   = 2'(b) - a_base[1:0];
        assign ab  = a_base + {30'd0, k};
        assign row = ab[AW-1:2];

        always_ff @(posedge clk)
        begin
            if (state_reg == BK_CLEAR)
                mem[clr_reg] <= 8'd0;
            else if (mem_wr && byte_en[k])
                mem[row] <= wr_data[8*k +: 8];
            if (mem_rd)
                bank_q[b] <= mem[row];
        end
    end

    // Register file read with bypass of the write at the same edge.
    always_comb
    begin
        rs1_rd = rf_vld_reg[q_item.word[19:15]] ? rf_mem[q_item.word[19:15]] : 32'd0;
        rs2_rd = rf_vld_reg[q_item.word[24:20]] ? rf_mem[q_item.word[24:20]] : 32'd0;
        if (finish && res.reg_written && res.dest_index == q_item.word[19:15])
            rs1_rd = res.dest_value;
        if (finish && res.reg_written && res.dest_index == q_item.word[24:20])
            rs2_rd = res.dest_value;
    end

    always_ff @(posedge clk)
    begin
        if (finish && res.reg_written)
            rf_mem[res.dest_index] <= res.dest_value;
        if (q_pop)
        begin
            item_reg <= q_item;
            rs1_reg  <= rs1_rd;
            rs2_reg  <= rs2_rd;
        end
        if (mem_rd)
            alo_reg <= a_base[1:0];
        if (finish)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 32'd0;
            rf_vld_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (finish && !res.illegal)
                pc_reg <= res.next_pc;
            if (finish && res.reg_written)
                rf_vld_reg[res.dest_index] <= 1'b1;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (res_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.next_pc     = out_reg.next_pc;
    assign res_ch.reg_written = out_reg.reg_written;
    assign res_ch.dest_index  = out_reg.dest_index;
    assign res_ch.dest_value  = out_reg.dest_value;
    assign res_ch.illegal     = out_reg.illegal;

endmodule

`default_nettype wire

[rtl/rv32i_instruction_execute.sv]
// Path: queue entry, item register, result register; a load adds the bank read.
// Throughput: one item a cycle while results are taken; a load also passes the
// LOAD state. The back end's single execute step and registered memory read set this.
// Reset: asynchronous, active low; afterwards the data memory is zeroed one
// four-byte row a cycle, during which no item is taken.
// ----------------------------------------------------------------------------
// rv32i_instruction_execute
// RV32I execute block: a front end that classifies items into a short
// queue, and a back end that executes them against the PC, registers and
// data memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_execute import rvx_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rvx_in_if.sink    in_ch,
    rvx_out_if.source res_ch
);

    // The queue between the halves lets the front keep taking transfers
    // while the back end waits on a stalled result channel.
    q_item_t    q_item;
    logic       q_valid;
    logic       q_pop;
    bk_status_t status;

    rvx_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .status  (status),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // The back end owns all architectural state: PC, register file and
    // the byte-banked data memory with its post-reset clearing pass.
    rvx_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .status  (status),
        .res_ch  (res_ch)
    );

endmodule

`default_nettype wire

[rtl/rvx_checker.sv]
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the result channel of the execute block.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        reg_written,
    input logic [4:0]  dest_index,
    input logic [31:0] dest_value,
    input logic        illegal
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal |-> !reg_written && dest_index == 5'd0 && dest_value == 32'd0)
        else $error("illegal item reports a write");

    a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_written |-> dest_index == 5'd0 && dest_value == 32'd0)
        else $error("destination fields set without a write");

    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_written |-> dest_index != 5'd0)
        else $error("write reported to x0");

endmodule

bind rv32i_instruction_execute rvx_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (res_ch.valid),
    .out_ready   (res_ch.ready),
    .reg_written (res_ch.reg_written),
    .dest_index  (res_ch.dest_index),
    .dest_value  (res_ch.dest_value),
    .illegal     (res_ch.illegal)
);

`default_nettype wire

[tb/rv32i_instruction_execute_test.sv]
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_test
// Self-checking bench for the RV32I execute block: it drives instruction and
// image-byte transfers, predicts every result from its own copy of the PC,
// register file and data memory, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class rv_scoreboard;
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        illegal;
    } rv_result_t;

    bit [31:0] pc;
    bit [31:0] regs [32];
    bit [7:0]  mem [65536];
    rv_result_t pending [$];
    int errors;

    function new();
        pc = 0;
        errors = 0;
        foreach (regs[i]) regs[i] = 0;
        foreach (mem[i]) mem[i] = 0;
    endfunction

    function bit [7:0] rd_mem(bit [31:0] a);
        return mem[a[15:0]];
    endfunction

    function bit signed_lt(bit [31:0] a, bit [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Work out the effect of one accepted transfer and queue its result.
    function void note_transfer(bit mode, bit [31:0] w, bit [15:0] ia, bit [7:0] ib);
        rv_result_t r;
        bit [6:0]  op;
        bit [4:0]  rd;
        bit [2:0]  f3;
        bit [6:0]  f7;
        bit [31:0] a1, a2, ii, is, ib_, ij, val, npc, ad;
        bit [7:0]  m0, m1, m2, m3;
        bit        wr, bad, take;
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
        a1 = regs[w[19:15]]; a2 = regs[w[24:20]];
        ii = {{20{w[31]}}, w[31:20]};
        is = {{20{w[31]}}, w[31:25], w[11:7]};
        ib_ = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        ij = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r = '0;
        r.next_pc = pc;
        wr = 0; bad = 0; val = 0; npc = pc + 4; take = 0;
        if (mode) begin
            mem[ia] = ib;
            pending.push_back(r);
            return;
        end
        case (op)
            rvx_pkg::OPC_OP: begin
                if (f7 == rvx_pkg::F7_ALT && f3 == 0) val = a1 - a2;
                else if (f7 == rvx_pkg::F7_ALT && f3 == 5) val = $signed(a1) >>> a2[4:0];
                else if (f7 != rvx_pkg::F7_ZERO) bad = 1;
                else case (f3)
                    0: val = a1 + a2;
                    1: val = a1 << a2[4:0];
                    2: val = {31'b0, signed_lt(a1, a2)};
                    3: val = {31'b0, a1 < a2};
                    4: val = a1 ^ a2;
                    5: val = a1 >> a2[4:0];
                    6: val = a1 | a2;
                    default: val = a1 & a2;
                endcase
                wr = !bad;
            end
            rvx_pkg::OPC_OPIMM: begin
                case (f3)
                    0: val = a1 + ii;
                    1: if (f7 != 0) bad = 1; else val = a1 << w[24:20];
                    2: val = {31'b0, signed_lt(a1, ii)};
                    3: val = {31'b0, a1 < ii};
                    4: val = a1 ^ ii;
                    5: if (f7 == rvx_pkg::F7_ZERO) val = a1 >> w[24:20];
                       else if (f7 == rvx_pkg::F7_ALT) val = $signed(a1) >>> w[24:20];
                       else bad = 1;
                    6: val = a1 | ii;
                    default: val = a1 & ii;
                endcase
                wr = !bad;
            end
            rvx_pkg::OPC_LOAD: begin
                ad = a1 + ii;
                m0 = rd_mem(ad);
                m1 = rd_mem(ad + 1);
                m2 = rd_mem(ad + 2);
                m3 = rd_mem(ad + 3);
                case (f3)
                    0: val = {{24{m0[7]}}, m0};
                    1: val = {{16{m1[7]}}, m1, m0};
                    2: val = {m3, m2, m1, m0};
                    4: val = {24'b0, m0};
                    5: val = {16'b0, m1, m0};
                    default: bad = 1;
                endcase
                wr = !bad;
            end
            rvx_pkg::OPC_STORE: begin
                ad = a1 + is;
                if (f3 > 2) bad = 1;
                else
                begin
                    mem[ad[15:0]] = a2[7:0];
                    if (f3 >= 1) mem[16'(ad + 1)] = a2[15:8];
                    if (f3 == 2)
                    begin
                        mem[16'(ad + 2)] = a2[23:16];
                        mem[16'(ad + 3)] = a2[31:24];
                    end
                end
            end
            rvx_pkg::OPC_BRANCH: begin
                case (f3)
                    0: take = a1 == a2;
                    1: take = a1 != a2;
                    4: take = signed_lt(a1, a2);
                    5: take = !signed_lt(a1, a2);
                    6: take = a1 < a2;
                    7: take = a1 >= a2;
                    default: bad = 1;
                endcase
                if (take) npc = pc + ib_;
            end
            rvx_pkg::OPC_JAL: begin
                val = pc + 4; wr = 1; npc = pc + ij;
            end
            rvx_pkg::OPC_JALR: begin
                if (f3 != 0) bad = 1;
                else
                begin
                    val = pc + 4; wr = 1; npc = (a1 + ii) & ~32'd1;
                end
            end
            rvx_pkg::OPC_LUI: begin
                val = {w[31:12], 12'b0}; wr = 1;
            end
            rvx_pkg::OPC_AUIPC: begin
                val = pc + {w[31:12], 12'b0}; wr = 1;
            end
            rvx_pkg::OPC_SYSTEM: begin
                if (w != rvx_pkg::WORD_ECALL && w != rvx_pkg::WORD_EBREAK) bad = 1;
            end
            default: bad = 1;
        endcase
        if (bad)
        begin
            r.illegal = 1;
        end
        else
        begin
            if (wr && rd != 0)
            begin
                regs[rd] = val;
                r.reg_written = 1; r.dest_index = rd; r.dest_value = val;
            end
            pc = npc;
            r.next_pc = npc;
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task check_result(rv_result_t got);
        rv_result_t e;
        if (pending.size() == 0)
        begin
            report("unexpected result", got.next_pc, 0);
            return;
        end
        e = pending.pop_front();
        if (got.next_pc !== e.next_pc) report("next_pc", got.next_pc, e.next_pc);
        if (got.reg_written !== e.reg_written)
            report("reg_written", got.reg_written, e.reg_written);
        if (got.dest_index !== e.dest_index) report("dest_index", got.dest_index, e.dest_index);
        if (got.dest_value !== e.dest_value) report("dest_value", got.dest_value, e.dest_value);
        if (got.illegal !== e.illegal) report("illegal", got.illegal, e.illegal);
    endtask
endclass

module rv32i_instruction_execute_test;
    import rvx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    rvx_in_if  in_ch ();
    rvx_out_if res_ch ();

    rv32i_instruction_execute u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .res_ch (res_ch.source)
    );

    rv_scoreboard sb;

    // When set, every cycle is busy on both sides; used for a stretch of the
    // random part.
    bit no_idle;
    // While non-zero, the result side holds ready low.
    int hold_cycles;
    bit stim_done;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.mode = 0;
        in_ch.instr_word = 0;
        in_ch.image_address = 0;
        in_ch.image_byte = 0;
        res_ch.ready = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
    end

    // The block zeroes its memory after reset, one row at a time, and a thousand
    // items sit far below this bound even with heavy idling.
    initial
    begin
        #20ms;
        $display("rv32i_instruction_execute regression: fail");
        $finish;
    end

    // Items are noted in the predictor at the edge where the transfer happens.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_transfer(in_ch.mode, in_ch.instr_word, in_ch.image_address,
                             in_ch.image_byte);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result({res_ch.next_pc, res_ch.reg_written, res_ch.dest_index,
                             res_ch.dest_value, res_ch.illegal});
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 0;
        end
        else
            res_ch.ready <= no_idle || ($urandom_range(99) >= 26);
    end

    // Offer one transfer and hold it until the block takes it; a random gap
    // may come first.
    task send(bit m, bit [31:0] w, bit [15:0] a, bit [7:0] b);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= m;
        in_ch.instr_word <= w;
        in_ch.image_address <= a;
        in_ch.image_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task go_quiet();
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function bit [31:0] r_type(bit [6:0] f7, bit [4:0] rs2, bit [4:0] rs1, bit [2:0] f3,
                               bit [4:0] rd, bit [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function bit [31:0] i_type(bit [11:0] imm, bit [4:0] rs1, bit [2:0] f3, bit [4:0] rd,
                               bit [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function bit [31:0] s_type(bit [11:0] imm, bit [4:0] rs2, bit [4:0] rs1, bit [2:0] f3,
                               bit [6:0] op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    // Mostly well-formed words with random fields, a few raw random words.
    // Registers are drawn from a small set so that results feed back.
    function bit [31:0] random_word();
        bit [4:0]  r1, r2, rd;
        bit [2:0]  f3;
        bit [11:0] imm;
        int k;
        r1 = 5'($urandom_range(7)); r2 = 5'($urandom_range(7)); rd = 5'($urandom_range(7));
        if ($urandom_range(9) == 0) rd = 5'($urandom);
        f3 = 3'($urandom); imm = 12'($urandom);
        if ($urandom_range(1)) imm = 12'($urandom_range(63)) - 12'd32;
        k = $urandom_range(99);
        if (k < 20)
            return r_type($urandom_range(3) == 0 ? F7_ALT : ($urandom_range(19) == 0 ?
                          7'($urandom) : F7_ZERO), r2, r1, f3, rd, OPC_OP);
        else if (k < 38)
        begin
            if (f3 == 1 || f3 == 5)
                imm = {$urandom_range(1) ? F7_ALT : F7_ZERO, 5'($urandom)};
            return i_type(imm, r1, f3, rd, OPC_OPIMM);
        end
        else if (k < 50) return i_type(imm, r1, f3, rd, OPC_LOAD);
        else if (k < 62) return s_type(imm, r2, r1, 3'($urandom_range(3)), OPC_STORE);
        else if (k < 72) return {$urandom_range(1) ? 7'h00 : 7'h7f, 5'($urandom), r2, r1,
                                 f3, 5'($urandom), OPC_BRANCH};
        else if (k < 76) return {20'($urandom), rd, OPC_JAL};
        else if (k < 80) return i_type(imm, r1, $urandom_range(4) == 0 ? f3 : 3'd0, rd,
                                       OPC_JALR);
        else if (k < 86) return {20'($urandom), rd, OPC_LUI};
        else if (k < 90) return {20'($urandom), rd, OPC_AUIPC};
        else if (k < 93) return $urandom_range(1) ? WORD_ECALL : WORD_EBREAK;
        else return $urandom;
    endfunction

    initial
    begin
        int hold_wait;
        sb = new();
        no_idle = 0;
        hold_cycles = 0;
        stim_done = 0;
        @(posedge clk iff rst_n);

        // Directed part: image bytes at both ends of memory, every operation
        // class, the extremes of the fields, x0 as destination, both system
        // words, wrapping and misaligned accesses, and unknown encodings.
        send(1, 32'hffff_ffff, 16'h0000, 8'hff);
        send(1, 32'h0, 16'hffff, 8'h80);
        send(0, i_type(12'hfff, 5'd0, 3'd0, 5'd1, OPC_OPIMM), 0, 0);
        send(0, i_type(12'h7ff, 5'd0, 3'd0, 5'd2, OPC_OPIMM), 0, 0);
        send(0, {20'h80000, 5'd3, OPC_LUI}, 0, 0);
        send(0, r_type(F7_ALT, 5'd1, 5'd3, 3'd5, 5'd4, OPC_OP), 0, 0);
        send(0, r_type(F7_ALT, 5'd2, 5'd1, 3'd0, 5'd0, OPC_OP), 0, 0);
        send(0, i_type(12'hfff, 5'd1, 3'd0, 5'd5, OPC_LOAD), 0, 0);
        send(0, i_type(12'hffe, 5'd0, 3'd2, 5'd6, OPC_LOAD), 0, 0);
        send(0, i_type(12'hfff, 5'd0, 3'd1, 5'd7, OPC_LOAD), 0, 0);
        send(0, s_type(12'hffe, 5'd3, 5'd0, 3'd2, OPC_STORE), 0, 0);
        send(0, i_type(12'h000, 5'd0, 3'd5, 5'd8, OPC_LOAD), 0, 0);
        send(0, {7'h7f, 5'd1, 5'd0, 3'd4, 5'h1f, OPC_BRANCH}, 0, 0);
        send(0, {20'hfffff, 5'd9, OPC_JAL}, 0, 0);
        send(0, i_type(12'h7ff, 5'd1, 3'd0, 5'd31, OPC_JALR), 0, 0);
        send(0, {20'hfffff, 5'd10, OPC_AUIPC}, 0, 0);
        send(0, WORD_ECALL, 0, 0);
        send(0, WORD_EBREAK, 0, 0);
        send(0, 32'h0000_100f, 0, 0);
        send(0, 32'h0000_1073, 0, 0);
        send(0, r_type(7'h01, 5'd1, 5'd1, 3'd0, 5'd1, OPC_OP), 0, 0);
        send(0, i_type(12'h41f, 5'd1, 3'd1, 5'd1, OPC_OPIMM), 0, 0);
        send(0, 32'h0, 0, 0);
        send(0, 32'hffff_ffff, 0, 0);

        // The sender waits here until every result is in.
        go_quiet();

        for (int n = 0; n < 1000; n++)
        begin
            no_idle = (n >= 300 && n < 450);
            // At one point the result side stops for a long stretch while items
            // keep coming, so the internal queue fills and input stalls.
            if (n == 600) hold_cycles = 200;
            if ($urandom_range(19) == 0)
                send(1, $urandom, $urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom),
                     8'($urandom));
            else
                send(0, random_word(), 16'($urandom), 8'($urandom));
        end
        in_ch.valid <= 0;

        hold_wait = 0;
        while (sb.pending.size() != 0 && hold_wait < 100000)
        begin
            @(posedge clk);
            hold_wait++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rv32i_instruction_execute regression: pass");
        else
            $display("rv32i_instruction_execute regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
